[design/afd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the API frame deframer.
// No dependencies; imported by every module of the block.
package afd_pkg;

  // Configuration port
  localparam int CFG_DW = 16;
  localparam int CFG_AW = 1;

  localparam logic [CFG_AW-1:0] REG_START_DELIM = 1'b0;
  localparam logic [CFG_AW-1:0] REG_FRAME_LIMIT = 1'b1;

  localparam logic [7:0]  START_DELIM_RST = 8'h7E;
  localparam logic [15:0] FRAME_LIMIT_RST = 16'h0100;

  // Command passed from the parser to the output stage.
  // pair: emit data_a then data_b as the two length bytes.
  // Otherwise emit data_a alone, flagged last when last is set.
  typedef struct packed {
    logic       pair;
    logic       last;
    logic [7:0] data_a;
    logic [7:0] data_b;
  } afd_cmd_t;

endpackage

[design/api_frame_deframer.sv]
`timescale 1ns / 1ps
// Top level of the API frame deframer: parser, command queue, output stage.
// Depends on afd_pkg, afd_front, afd_queue and afd_back.
//
// The deframer accepts one received byte per cycle while its command queue
// has room; bytes with attention low are consumed without effect. The first
// result of a byte passes through the queue and the output register: the
// queue entry is written at the accepting edge, and the output register loads
// it once that register is free and the entry is at the head of the queue.
// Results leave at one per cycle while out_stall_i is low; the second
// length byte of a frame turns into two results, so the output stage emits
// the held low length byte before it pops the next command. The QueueDepth-entry
// queue between parser and output stage absorbs output stalls and the extra
// length result; once it is full, rx_stall_o rises until the output side
// drains an entry. There is no clearing pass after reset.
module api_frame_deframer #(
  parameter int QueueDepth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [afd_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [afd_pkg::CFG_DW-1:0] cfg_wdata_i,
  input  logic                       rx_valid_i,
  output logic                       rx_stall_o,
  input  logic [7:0]                 rx_byte_i,
  input  logic                       attention_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 frame_byte_o,
  output logic                       is_length_byte_o,
  output logic                       is_last_o
);
  import afd_pkg::*;

  logic     push, q_ready, q_valid, pop;
  afd_cmd_t push_cmd, q_cmd;

  // Parse incoming bytes
  afd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_valid_i  (rx_valid_i),
    .rx_stall_o  (rx_stall_o),
    .rx_byte_i   (rx_byte_i),
    .attention_i (attention_i),
    .q_ready_i   (q_ready),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Decouple parser from output
  afd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (q_cmd)
  );

  // Emit result transactions
  afd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_data_i         (q_cmd),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_byte_o     (frame_byte_o),
    .is_length_byte_o (is_length_byte_o),
    .is_last_o        (is_last_o)
  );

endmodule

[design/afd_front.sv]
`timescale 1ns / 1ps
// Front end of the deframer: configuration registers, frame parser.
// Depends on afd_pkg; pushes commands into afd_queue.
module afd_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [afd_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [afd_pkg::CFG_DW-1:0] cfg_wdata_i,
  input  logic                       rx_valid_i,
  output logic                       rx_stall_o,
  input  logic [7:0]                 rx_byte_i,
  input  logic                       attention_i,
  input  logic                       q_ready_i,
  output logic                       push_o,
  output afd_pkg::afd_cmd_t          cmd_o
);
  import afd_pkg::*;

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_LEN_HI = 2'd1;
  localparam logic [1:0] PH_LEN_LO = 2'd2;
  localparam logic [1:0] PH_DATA   = 2'd3;

  logic [7:0]  start_delim_q;
  logic [15:0] frame_limit_q;
  logic [1:0]  phase_q, phase_d;
  logic [15:0] frame_len_q, frame_len_d;
  logic [15:0] rx_cnt_q, rx_cnt_d;
  logic        take;
  logic [15:0] len_full;

  // Stall while the queue has no room
  assign rx_stall_o = !q_ready_i;
  assign take       = rx_valid_i && !rx_stall_o && attention_i;
  assign len_full   = {frame_len_q[15:8], rx_byte_i};

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_delim_q <= START_DELIM_RST;
      frame_limit_q <= FRAME_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_DELIM: start_delim_q <= cfg_wdata_i[7:0];
        REG_FRAME_LIMIT: frame_limit_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Classify each transaction and build the command
  always_comb begin
    phase_d     = phase_q;
    frame_len_d = frame_len_q;
    rx_cnt_d    = rx_cnt_q;
    push_o      = 1'b0;
    cmd_o       = '{pair: 1'b0, last: 1'b0, data_a: rx_byte_i, data_b: rx_byte_i};
    if (take) begin
      case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == start_delim_q) phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          frame_len_d = {rx_byte_i, 8'h00};
          phase_d     = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          frame_len_d = len_full;
          if (len_full == 16'h0000 || len_full >= frame_limit_q) begin
            phase_d = PH_HUNT;
          end else begin
            push_o       = 1'b1;
            cmd_o.pair   = 1'b1;
            cmd_o.data_a = frame_len_q[15:8];
            cmd_o.data_b = rx_byte_i;
            rx_cnt_d     = '0;
            phase_d      = PH_DATA;
          end
        end
        default: begin
          push_o = 1'b1;
          if (rx_cnt_q < frame_len_q) begin
            rx_cnt_d = rx_cnt_q + 16'd1;
          end else begin
            cmd_o.last = 1'b1;
            phase_d    = PH_HUNT;
          end
        end
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      frame_len_q <= '0;
      rx_cnt_q    <= '0;
    end else begin
      phase_q     <= phase_d;
      frame_len_q <= frame_len_d;
      rx_cnt_q    <= rx_cnt_d;
    end
  end

endmodule

[design/afd_queue.sv]
`timescale 1ns / 1ps
// Small command queue between the parser and the output stage.
// Depends on afd_pkg for the command type.
module afd_queue #(
  parameter int Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  afd_pkg::afd_cmd_t wdata_i,
  output logic              ready_o,
  input  logic              pop_i,
  output logic              valid_o,
  output afd_pkg::afd_cmd_t rdata_o
);
  import afd_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  afd_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign ready_o = (cnt_q != FullCnt);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Store the incoming command
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[design/afd_back.sv]
`timescale 1ns / 1ps
// Output stage: expands queued commands into result transactions.
// Depends on afd_pkg; reads from afd_queue.
module afd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  afd_pkg::afd_cmd_t q_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        frame_byte_o,
  output logic              is_length_byte_o,
  output logic              is_last_o
);
  import afd_pkg::*;

  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic       out_len_q;
  logic       out_last_q;
  logic       pend_q;
  logic [7:0] pend_data_q;
  logic       load;

  // Output register is free or is being taken this cycle
  assign load  = !out_valid_q || !out_stall_i;
  assign pop_o = load && !pend_q && q_valid_i;

  // Control: output valid and pending low length byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (load) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else begin
        out_valid_q <= q_valid_i;
        pend_q      <= q_valid_i && q_data_i.pair;
      end
    end
  end

  // Payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        out_data_q <= pend_data_q;
        out_len_q  <= 1'b1;
        out_last_q <= 1'b0;
      end else if (q_valid_i) begin
        out_data_q  <= q_data_i.data_a;
        out_len_q   <= q_data_i.pair;
        out_last_q  <= q_data_i.last && !q_data_i.pair;
        pend_data_q <= q_data_i.data_b;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_byte_o     = out_data_q;
  assign is_length_byte_o = out_len_q;
  assign is_last_o        = out_last_q;

endmodule
